FILE: src/raster_carve_stepper_sequencer_macros.svh
// ----------------------------------------------------------------------------
// raster carve stepper sequencer assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef RASTER_CARVE_STEPPER_SEQUENCER_MACROS_SVH
`define RASTER_CARVE_STEPPER_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define RCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcs assertion failed");

// next-cycle implication, disabled while reset is held
`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcs assertion failed");

`endif

FILE: src/rcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_pkg
// shared types, constants and helpers of the raster carve stepper sequencer
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLUMNS = 256;

    localparam int ROW_LIMIT_I = (MAX_ROWS < 256) ? MAX_ROWS : 256;
    localparam int COL_LIMIT_I = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
    localparam logic [8:0] ROW_LIMIT = 9'(ROW_LIMIT_I);
    localparam logic [8:0] COL_LIMIT = 9'(COL_LIMIT_I);

    // register reset values
    localparam logic [7:0]  THRESHOLD_RESET      = 8'd127;
    localparam logic [15:0] Z_MOVE_STEPS_RESET   = 16'd8000;
    localparam logic [15:0] Y_MOVE_TOGGLES_RESET = 16'd400;
    localparam logic [15:0] X_MOVE_TOGGLES_RESET = 16'd400;
    localparam logic [8:0]  ROW_COUNT_RESET      = 9'd64;
    localparam logic [8:0]  COLUMN_COUNT_RESET   = 9'd64;

    // register indexes
    localparam logic [2:0] REG_THRESHOLD      = 3'd0;
    localparam logic [2:0] REG_Z_MOVE_STEPS   = 3'd1;
    localparam logic [2:0] REG_Y_MOVE_TOGGLES = 3'd2;
    localparam logic [2:0] REG_X_MOVE_TOGGLES = 3'd3;
    localparam logic [2:0] REG_ROW_COUNT      = 3'd4;
    localparam logic [2:0] REG_COLUMN_COUNT   = 3'd5;

    typedef enum logic [1:0] {
        REQ_XY    = 2'd0,
        REQ_Z     = 2'd1,
        REQ_PIXEL = 2'd2,
        REQ_NONE  = 2'd3
    } rcs_req_t;

    typedef enum logic [2:0] {
        MOVE_IDLE   = 3'b001,
        MOVE_PIXEL  = 3'b010,
        MOVE_RETURN = 3'b100
    } rcs_move_t;

    // live configuration as seen by the step logic
    typedef struct packed {
        logic [7:0]  threshold;
        logic [15:0] z_move_steps;
        logic [15:0] y_move_toggles;
        logic [15:0] x_move_toggles;
        logic [23:0] return_toggles;
        logic [8:0]  rows_eff;
        logic [8:0]  cols_eff;
    } rcs_cfg_t;

    typedef struct packed {
        logic       rejected;
        logic       carved;
        logic       busy_res;
        logic       spindle_on;
        logic [3:0] coil_pattern;
        logic       y_direction;
        logic       y_step_level;
        logic       x_step_level;
    } rcs_result_t;

    // clamp a count to 1..limit
    function automatic logic [8:0] eff_count(input logic [8:0] c, input logic [8:0] lim);
        logic [8:0] r;
        r = c;
        if (c == 9'd0)
            r = 9'd1;
        else if (c > lim)
            r = lim;
        return r;
    endfunction

    // four-phase coil drive, msb first dir, ndir, stp, nstp
    function automatic logic [3:0] coil_drive(input logic [1:0] phase);
        logic [3:0] d;
        case (phase)
            2'd0:    d = 4'b1010;
            2'd1:    d = 4'b0110;
            2'd2:    d = 4'b0101;
            default: d = 4'b1001;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: src/raster_carve_stepper_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// raster_carve_stepper_sequencer
// three-axis stepper sequencer that carves a raster image pixel by pixel
// ----------------------------------------------------------------------------
// The block takes one beat per clock on the input stream while the output is
// not stalled and returns exactly one result beat for each, in order. A beat
// is first captured in an input register; when it advances, the step logic
// updates the motion state (step counters, coil phase, tool and spindle state,
// raster position) and the result lands in the output register, from which
// the result beat is offered. Throughput is one beat per cycle while the
// output is not stalled, limited only by the single step stage between the
// two registers; a stalled output holds the pipeline and drops input ready
// once the input register holds a beat. Configuration writes are taken at any
// edge with cfg_we high and should only be issued with the block idle.
// ----------------------------------------------------------------------------
module raster_carve_stepper_sequencer import rcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel_value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [0] x_step_level, [1] y_step_level,
                                             // [2] y_direction, [6:3] coil_pattern,
                                             // [7] spindle_on, [8] busy_res,
                                             // [9] carved, [10] rejected, [15:11] zero
);

    rcs_cfg_t    cfg;
    rcs_result_t result;

    logic        in_valid_reg;
    rcs_req_t    req_reg;
    logic [7:0]  pix_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        advance;
    logic        in_take;

    // step fires when a beat is held and the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    rcs_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg <= rcs_req_t'(s_axis_tuser);
            pix_reg <= s_axis_tdata;
        end
    end

    rcs_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req_reg),
        .pixel   (pix_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {5'd0, result.rejected, result.carved, result.busy_res,
                             result.spindle_on, result.coil_pattern, result.y_direction,
                             result.y_step_level, result.x_step_level};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

FILE: src/rcs_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_cfg
// configuration registers, clamped counts and row-return length
// ----------------------------------------------------------------------------
module rcs_cfg import rcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output rcs_cfg_t         cfg
);

    logic [7:0]  threshold_reg;
    logic [15:0] z_move_steps_reg;
    logic [15:0] y_move_toggles_reg;
    logic [15:0] x_move_toggles_reg;
    logic [8:0]  row_count_reg;
    logic [8:0]  column_count_reg;
    logic [8:0]  cols_eff;
    logic [23:0] return_product;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg      <= THRESHOLD_RESET;
            z_move_steps_reg   <= Z_MOVE_STEPS_RESET;
            y_move_toggles_reg <= Y_MOVE_TOGGLES_RESET;
            x_move_toggles_reg <= X_MOVE_TOGGLES_RESET;
            row_count_reg      <= ROW_COUNT_RESET;
            column_count_reg   <= COLUMN_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:      threshold_reg      <= cfg_data[7:0];
                REG_Z_MOVE_STEPS:   z_move_steps_reg   <= cfg_data;
                REG_Y_MOVE_TOGGLES: y_move_toggles_reg <= cfg_data;
                REG_X_MOVE_TOGGLES: x_move_toggles_reg <= cfg_data;
                REG_ROW_COUNT:      row_count_reg      <= cfg_data[8:0];
                REG_COLUMN_COUNT:   column_count_reg   <= cfg_data[8:0];
                default:            ; // unknown index, dropped
            endcase
        end
    end

    // row-return length, at most 65535 * 256 so it fits 24 bits
    assign cols_eff       = eff_count(column_count_reg, COL_LIMIT);
    assign return_product = 24'(y_move_toggles_reg * cols_eff);

    always_comb
    begin
        cfg.threshold      = threshold_reg;
        cfg.z_move_steps   = z_move_steps_reg;
        cfg.y_move_toggles = y_move_toggles_reg;
        cfg.x_move_toggles = x_move_toggles_reg;
        cfg.return_toggles = return_product;
        cfg.rows_eff       = eff_count(row_count_reg, ROW_LIMIT);
        cfg.cols_eff       = cols_eff;
    end

endmodule
`default_nettype wire

FILE: src/rcs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_step
// motion state registers and the single-pass update for one request
// ----------------------------------------------------------------------------
module rcs_step import rcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire rcs_req_t    req,
    input  wire logic [7:0]  pixel,
    input  wire rcs_cfg_t    cfg,
    output rcs_result_t      result
);

    logic [15:0] x_rem_reg,   x_rem_next;
    logic [23:0] y_rem_reg,   y_rem_next;
    logic [15:0] z_rem_reg,   z_rem_next;
    logic [1:0]  phase_reg,   phase_next;
    logic [3:0]  coil_reg,    coil_next;
    logic        raising_reg, raising_next;
    logic        lowered_reg, lowered_next;
    logic        spindle_reg, spindle_next;
    logic [1:0]  levels_reg,  levels_next;
    logic        ret_dir_reg, ret_dir_next;
    logic [7:0]  row_reg,     row_next;
    logic [7:0]  col_reg,     col_next;
    rcs_move_t   move_reg,    move_next;
    logic        done_reg,    done_next;
    logic        rejected;

    always_comb
    begin
        x_rem_next   = x_rem_reg;
        y_rem_next   = y_rem_reg;
        z_rem_next   = z_rem_reg;
        phase_next   = phase_reg;
        coil_next    = coil_reg;
        raising_next = raising_reg;
        lowered_next = lowered_reg;
        spindle_next = spindle_reg;
        levels_next  = levels_reg;
        ret_dir_next = ret_dir_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        move_next    = move_reg;
        done_next    = done_reg;
        rejected     = 1'b0;

        unique case (req)
            REQ_XY:
            begin
                // pins only move once z has settled
                if (z_rem_reg == 16'd0)
                begin
                    if (y_rem_reg != 24'd0)
                    begin
                        levels_next[1] = ~levels_reg[1];
                        y_rem_next     = y_rem_reg - 24'd1;
                    end
                    if (x_rem_reg != 16'd0)
                    begin
                        levels_next[0] = ~levels_reg[0];
                        x_rem_next     = x_rem_reg - 16'd1;
                    end
                end
                if (move_reg != MOVE_IDLE && x_rem_next == 16'd0 &&
                    y_rem_next == 24'd0 && z_rem_reg == 16'd0)
                begin
                    unique case (move_reg)
                        MOVE_PIXEL:
                        begin
                            if (({1'b0, col_reg} + 9'd1) >= cfg.cols_eff)
                            begin
                                // end of row: lift, stop, run y back and step x
                                col_next     = 8'd0;
                                spindle_next = 1'b0;
                                ret_dir_next = 1'b1;
                                if (lowered_reg)
                                begin
                                    lowered_next = 1'b0;
                                    raising_next = 1'b1;
                                    z_rem_next   = cfg.z_move_steps;
                                end
                                else
                                    z_rem_next = 16'd0;
                                y_rem_next = cfg.return_toggles;
                                x_rem_next = cfg.x_move_toggles;
                                move_next  = MOVE_RETURN;
                            end
                            else
                            begin
                                col_next  = col_reg + 8'd1;
                                move_next = MOVE_IDLE;
                            end
                        end
                        default:
                        begin
                            ret_dir_next = 1'b0;
                            move_next    = MOVE_IDLE;
                            if (({1'b0, row_reg} + 9'd1) >= cfg.rows_eff)
                            begin
                                // last row: final raise
                                row_next     = 8'd0;
                                spindle_next = 1'b0;
                                if (lowered_reg)
                                begin
                                    lowered_next = 1'b0;
                                    raising_next = 1'b1;
                                    z_rem_next   = cfg.z_move_steps;
                                end
                                else
                                    z_rem_next = 16'd0;
                                done_next = 1'b1;
                            end
                            else
                                row_next = row_reg + 8'd1;
                        end
                    endcase
                end
            end
            REQ_Z:
            begin
                if (z_rem_reg != 16'd0)
                begin
                    coil_next  = coil_drive(phase_reg);
                    phase_next = raising_reg ? phase_reg - 2'd1 : phase_reg + 2'd1;
                    z_rem_next = z_rem_reg - 16'd1;
                end
            end
            REQ_PIXEL:
            begin
                if (move_reg != MOVE_IDLE || done_reg)
                    rejected = 1'b1;
                else
                begin
                    if (pixel > cfg.threshold)
                    begin
                        spindle_next = 1'b0;
                        if (lowered_reg)
                        begin
                            lowered_next = 1'b0;
                            raising_next = 1'b1;
                            z_rem_next   = cfg.z_move_steps;
                        end
                        else
                            z_rem_next = 16'd0;
                    end
                    else
                    begin
                        spindle_next = 1'b1;
                        if (!lowered_reg)
                        begin
                            lowered_next = 1'b1;
                            raising_next = 1'b0;
                            z_rem_next   = cfg.z_move_steps;
                        end
                        else
                            z_rem_next = 16'd0;
                    end
                    y_rem_next = {8'd0, cfg.y_move_toggles};
                    move_next  = MOVE_PIXEL;
                end
            end
            REQ_NONE: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_rem_reg   <= '0;
            y_rem_reg   <= '0;
            z_rem_reg   <= '0;
            phase_reg   <= '0;
            coil_reg    <= '0;
            raising_reg <= 1'b0;
            lowered_reg <= 1'b0;
            spindle_reg <= 1'b0;
            levels_reg  <= '0;
            ret_dir_reg <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
            move_reg    <= MOVE_IDLE;
            done_reg    <= 1'b0;
        end
        else if (advance)
        begin
            x_rem_reg   <= x_rem_next;
            y_rem_reg   <= y_rem_next;
            z_rem_reg   <= z_rem_next;
            phase_reg   <= phase_next;
            coil_reg    <= coil_next;
            raising_reg <= raising_next;
            lowered_reg <= lowered_next;
            spindle_reg <= spindle_next;
            levels_reg  <= levels_next;
            ret_dir_reg <= ret_dir_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            move_reg    <= move_next;
            done_reg    <= done_next;
        end
    end

    always_comb
    begin
        result.rejected     = rejected;
        result.carved       = done_next;
        result.busy_res     = (move_next != MOVE_IDLE);
        result.spindle_on   = spindle_next;
        result.coil_pattern = coil_next;
        result.y_direction  = ret_dir_next;
        result.y_step_level = levels_next[1];
        result.x_step_level = levels_next[0];
    end

endmodule
`default_nettype wire

FILE: src/rcs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_checker
// port-level checks of the raster carve stepper sequencer
// ----------------------------------------------------------------------------
`include "raster_carve_stepper_sequencer_macros.svh"

module rcs_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata
);

    logic carved_seen_reg;

    // carving, once reported, never ends before reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            carved_seen_reg <= 1'b0;
        else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[9])
            carved_seen_reg <= 1'b1;
    end

    `RCS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))
    `RCS_ASSERT_NOW(a_carved_sticky, clk, rst_n, m_axis_tvalid && carved_seen_reg,
                    m_axis_tdata[9])
    `RCS_ASSERT_NOW(a_reject_cause, clk, rst_n, m_axis_tvalid && m_axis_tdata[10],
                    m_axis_tdata[8] || m_axis_tdata[9])
    `RCS_ASSERT_NOW(a_carved_quiet, clk, rst_n, m_axis_tvalid && m_axis_tdata[9],
                    !m_axis_tdata[7] && !m_axis_tdata[8] && !m_axis_tdata[2])

endmodule

bind raster_carve_stepper_sequencer rcs_checker u_rcs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
